### hdl/plug_detect_auth_sequencer_macros.svh
// assertion macros for the plug detect sequencer
`ifndef PLUG_DETECT_AUTH_SEQUENCER_MACROS_SVH
`define PLUG_DETECT_AUTH_SEQUENCER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDAS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PDAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pdas_pkg.sv
// shared types and codes for the plug detect sequencer
`default_nettype none

package pdas_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_INSERT_DEBOUNCE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REMOVE_DEBOUNCE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VERIFY_DELAY    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_MAJOR  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_KNOWN_TYPES     = 3'd4;

    localparam logic [7:0] RST_INSERT_DEBOUNCE = 8'd5;
    localparam logic [7:0] RST_REMOVE_DEBOUNCE = 8'd5;
    localparam logic [7:0] RST_VERIFY_DELAY    = 8'd10;
    localparam logic [7:0] RST_EXPECTED_MAJOR  = 8'h6B;
    localparam logic [7:0] RST_KNOWN_TYPES     = 8'd12;

    localparam logic [1:0] ALARM_NONE          = 2'd0;
    localparam logic [1:0] ALARM_RUN_UNPLUG    = 2'd1;
    localparam logic [1:0] ALARM_VERIFY_FAIL   = 2'd2;
    localparam logic [1:0] ALARM_INFO_FAIL     = 2'd3;

    localparam logic [1:0] SCREEN_NONE         = 2'd0;
    localparam logic [1:0] SCREEN_ONLINE       = 2'd1;
    localparam logic [1:0] SCREEN_OFFLINE      = 2'd2;

    typedef struct packed {
        logic [7:0] insert_debounce_ticks;
        logic [7:0] remove_debounce_ticks;
        logic [7:0] verify_delay_ticks;
        logic [7:0] expected_major_id;
        logic [7:0] known_type_count;
    } cfg_t;

    typedef struct packed {
        logic       plugged;
        logic       verify_ok;
        logic       info_read_ok;
        logic [7:0] id_major;
        logic [7:0] id_minor;
        logic       motor_running;
    } item_t;

    typedef struct packed {
        logic [2:0] stage;
        logic       online;
        logic       chip_recognized;
        logic       short_recognized;
        logic [7:0] model_index;
        logic [1:0] alarm_code;
        logic       motor_stop;
        logic [1:0] screen_event;
    } result_t;

endpackage

`default_nettype wire

### hdl/plug_detect_auth_sequencer.sv
// plug detect and authentication sequencer top level
// result: each item is held in the input register, then its result in the result register
// throughput: one item per cycle while result_stall is low, set by the combinational stage and counter update
// reset: stage idle, counters, flags and model cleared, config back to defaults
// reset: both pipeline registers empty, no clearing pass
`default_nettype none
`include "plug_detect_auth_sequencer_macros.svh"

module plug_detect_auth_sequencer
#(
    parameter int COUNTER_WIDTH = 8
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire pdas_pkg::item_t                  item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output pdas_pkg::result_t                     result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pdas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data
);

    localparam int CMP_W = (COUNTER_WIDTH > 8) ? COUNTER_WIDTH : 8;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << COUNTER_WIDTH) - 1);
    localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_DEB_IN  = 3'd1,
        ST_WAIT    = 3'd2,
        ST_VERIFY  = 3'd3,
        ST_INFO    = 3'd4,
        ST_ONLINE  = 3'd5,
        ST_DEB_OUT = 3'd6,
        ST_FAIL    = 3'd7
    } stage_t;

    pdas_pkg::cfg_t cfg;

    pdas_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign cfg_ready = 1'b1;

    logic                     item_valid_reg;
    pdas_pkg::item_t          item_reg;
    logic                     result_valid_reg;
    pdas_pkg::result_t        result_reg;

    stage_t                   stage_reg, stage_next;
    logic [COUNTER_WIDTH-1:0] insert_count_reg, insert_count_next;
    logic [COUNTER_WIDTH-1:0] remove_count_reg, remove_count_next;
    logic [COUNTER_WIDTH-1:0] delay_count_reg, delay_count_next;
    logic [7:0]               model_reg, model_next;
    logic                     online_reg, online_next;
    logic                     chip_reg, chip_next;
    logic                     short_reg, short_next;
    logic [1:0]               alarm;
    logic                     motor_stop;
    logic [1:0]               screen;

    logic                     advance;
    logic [CMP_W-1:0]         lim_insert, lim_remove, lim_delay;
    logic [CMP_W-1:0]         thr_insert, thr_remove, thr_delay;
    logic [COUNTER_WIDTH-1:0] insert_eff, remove_eff;
    logic                     insert_pass, remove_pass, delay_pass;
    logic                     id_ok;

    assign advance    = item_valid_reg & (~result_valid_reg | ~result_stall);
    assign item_stall = item_valid_reg & ~advance;

    // clamp thresholds to what the counters can hold
    assign thr_insert = CMP_W'(cfg.insert_debounce_ticks);
    assign thr_remove = CMP_W'(cfg.remove_debounce_ticks);
    assign thr_delay  = CMP_W'(cfg.verify_delay_ticks);
    assign lim_insert = (thr_insert > CNT_MAX) ? CNT_MAX : thr_insert;
    assign lim_remove = (thr_remove > CNT_MAX) ? CNT_MAX : thr_remove;
    assign lim_delay  = (thr_delay > CNT_MAX) ? CNT_MAX : thr_delay;

    assign insert_eff  = (stage_reg == ST_IDLE) ? '0 : insert_count_reg;
    assign remove_eff  = (stage_reg == ST_DEB_OUT) ? remove_count_reg : '0;
    assign insert_pass = ~(CMP_W'(insert_eff) < lim_insert);
    assign remove_pass = ~(CMP_W'(remove_eff) < lim_remove);
    assign delay_pass  = ~(CMP_W'(delay_count_reg) < lim_delay);

    assign id_ok = item_reg.info_read_ok
                 & (item_reg.id_major == cfg.expected_major_id)
                 & (item_reg.id_minor != 8'd0)
                 & (item_reg.id_minor <= cfg.known_type_count);

    always_comb
    begin
        stage_next        = stage_reg;
        insert_count_next = insert_count_reg;
        remove_count_next = remove_count_reg;
        delay_count_next  = delay_count_reg;
        model_next        = model_reg;
        online_next       = online_reg;
        chip_next         = chip_reg;
        short_next        = short_reg;
        alarm             = pdas_pkg::ALARM_NONE;
        motor_stop        = 1'b0;
        screen            = pdas_pkg::SCREEN_NONE;

        if (!item_reg.plugged)
        begin
            insert_count_next = '0;
            delay_count_next  = '0;
            if (stage_reg == ST_ONLINE || stage_reg == ST_DEB_OUT || stage_reg == ST_FAIL)
            begin
                if (!remove_pass)
                begin
                    remove_count_next = remove_eff + CNT_ONE;
                    stage_next        = ST_DEB_OUT;
                end
                else
                begin
                    remove_count_next = '0;
                    stage_next        = ST_IDLE;
                    online_next       = 1'b0;
                    chip_next         = 1'b0;
                    short_next        = 1'b0;
                    model_next        = '0;
                    screen            = pdas_pkg::SCREEN_OFFLINE;
                    if (item_reg.motor_running)
                    begin
                        alarm      = pdas_pkg::ALARM_RUN_UNPLUG;
                        motor_stop = 1'b1;
                    end
                end
            end
            else
            begin
                remove_count_next = '0;
                stage_next        = ST_IDLE;
                online_next       = 1'b0;
                chip_next         = 1'b0;
                short_next        = 1'b0;
            end
        end
        else
        begin
            case (stage_reg)
                ST_IDLE, ST_DEB_IN:
                begin
                    if (stage_reg == ST_IDLE)
                    begin
                        remove_count_next = '0;
                        delay_count_next  = '0;
                    end
                    if (!insert_pass)
                    begin
                        insert_count_next = insert_eff + CNT_ONE;
                        stage_next        = ST_DEB_IN;
                    end
                    else
                    begin
                        insert_count_next = '0;
                        delay_count_next  = '0;
                        stage_next        = ST_WAIT;
                        short_next        = 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    if (!delay_pass)
                    begin
                        delay_count_next = delay_count_reg + CNT_ONE;
                    end
                    else
                    begin
                        delay_count_next = '0;
                        // verify and info read resolve within this transfer
                        if (!item_reg.verify_ok)
                        begin
                            alarm      = pdas_pkg::ALARM_VERIFY_FAIL;
                            stage_next = ST_FAIL;
                        end
                        else if (!id_ok)
                        begin
                            alarm      = pdas_pkg::ALARM_INFO_FAIL;
                            stage_next = ST_FAIL;
                        end
                        else
                        begin
                            model_next  = item_reg.id_minor;
                            online_next = 1'b1;
                            chip_next   = 1'b1;
                            short_next  = 1'b1;
                            screen      = pdas_pkg::SCREEN_ONLINE;
                            stage_next  = ST_ONLINE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            item_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            stage_reg        <= ST_IDLE;
            insert_count_reg <= '0;
            remove_count_reg <= '0;
            delay_count_reg  <= '0;
            model_reg        <= '0;
            online_reg       <= 1'b0;
            chip_reg         <= 1'b0;
            short_reg        <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                item_reg <= item;
            end
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg            <= 1'b1;
                result_reg.stage            <= stage_next;
                result_reg.online           <= online_next;
                result_reg.chip_recognized  <= chip_next;
                result_reg.short_recognized <= short_next;
                result_reg.model_index      <= model_next;
                result_reg.alarm_code       <= alarm;
                result_reg.motor_stop       <= motor_stop;
                result_reg.screen_event     <= screen;
                stage_reg                   <= stage_next;
                insert_count_reg            <= insert_count_next;
                remove_count_reg            <= remove_count_next;
                delay_count_reg             <= delay_count_next;
                model_reg                   <= model_next;
                online_reg                  <= online_next;
                chip_reg                    <= chip_next;
                short_reg                   <= short_next;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PDAS_ASSERT_IMPLY(a_stop_is_unplug, result_valid && result.motor_stop, result.alarm_code == pdas_pkg::ALARM_RUN_UNPLUG && result.screen_event == pdas_pkg::SCREEN_OFFLINE, "motor stop without running unplug")
    `PDAS_ASSERT_IMPLY(a_online_stage, result_valid && result.online, result.stage == ST_ONLINE || result.stage == ST_DEB_OUT, "online flag outside online stages")
    `PDAS_ASSERT_IMPLY(a_no_transient, result_valid, result.stage != ST_VERIFY && result.stage != ST_INFO, "transient stage reported")
    `PDAS_ASSERT_NEXT(a_advance_result, advance, result_valid, "advanced item produced no result")

endmodule

`default_nettype wire

### hdl/pdas_cfg.sv
// configuration register file for the plug detect sequencer
`default_nettype none

module pdas_cfg
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [pdas_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data,
    output pdas_pkg::cfg_t                        cfg
);

    pdas_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.insert_debounce_ticks <= pdas_pkg::RST_INSERT_DEBOUNCE;
            cfg_reg.remove_debounce_ticks <= pdas_pkg::RST_REMOVE_DEBOUNCE;
            cfg_reg.verify_delay_ticks    <= pdas_pkg::RST_VERIFY_DELAY;
            cfg_reg.expected_major_id     <= pdas_pkg::RST_EXPECTED_MAJOR;
            cfg_reg.known_type_count      <= pdas_pkg::RST_KNOWN_TYPES;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                pdas_pkg::REG_INSERT_DEBOUNCE: cfg_reg.insert_debounce_ticks <= cfg_data;
                pdas_pkg::REG_REMOVE_DEBOUNCE: cfg_reg.remove_debounce_ticks <= cfg_data;
                pdas_pkg::REG_VERIFY_DELAY:    cfg_reg.verify_delay_ticks    <= cfg_data;
                pdas_pkg::REG_EXPECTED_MAJOR:  cfg_reg.expected_major_id     <= cfg_data;
                pdas_pkg::REG_KNOWN_TYPES:     cfg_reg.known_type_count      <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### tb/plug_detect_auth_sequencer_tb.sv
// self-checking testbench for the plug detect sequencer, directed and random ticks against a tick model
module plug_detect_auth_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNTER_WIDTH = 8;
    localparam int COUNT_MAX = (1 << COUNTER_WIDTH) - 1;
    localparam int INDEX_W = pdas_pkg::CFG_INDEX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEB_IN,
        ST_WAIT,
        ST_VERIFY,
        ST_INFO,
        ST_ONLINE,
        ST_DEB_OUT,
        ST_FAIL
    } stage_e;

    class status_scoreboard;
        pdas_pkg::cfg_t regs;
        stage_e stage;
        int insert_count;
        int remove_count;
        int delay_count;
        logic [7:0] model;
        logic fl_online;
        logic fl_chip;
        logic fl_short;
        logic [1:0] ev_alarm;
        logic [1:0] ev_screen;
        logic ev_stop;
        pdas_pkg::result_t due_status[$];
        int errors;

        function new();
            regs.insert_debounce_ticks = pdas_pkg::RST_INSERT_DEBOUNCE;
            regs.remove_debounce_ticks = pdas_pkg::RST_REMOVE_DEBOUNCE;
            regs.verify_delay_ticks = pdas_pkg::RST_VERIFY_DELAY;
            regs.expected_major_id = pdas_pkg::RST_EXPECTED_MAJOR;
            regs.known_type_count = pdas_pkg::RST_KNOWN_TYPES;
            stage = ST_IDLE;
            insert_count = 0;
            remove_count = 0;
            delay_count = 0;
            model = '0;
            fl_online = 1'b0;
            fl_chip = 1'b0;
            fl_short = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [7:0] val);
            case (idx)
                pdas_pkg::REG_INSERT_DEBOUNCE: regs.insert_debounce_ticks = val;
                pdas_pkg::REG_REMOVE_DEBOUNCE: regs.remove_debounce_ticks = val;
                pdas_pkg::REG_VERIFY_DELAY:    regs.verify_delay_ticks = val;
                pdas_pkg::REG_EXPECTED_MAJOR:  regs.expected_major_id = val;
                pdas_pkg::REG_KNOWN_TYPES:     regs.known_type_count = val;
                default: ;
            endcase
        endfunction

        function int limit(logic [7:0] t);
            return (int'(t) > COUNT_MAX) ? COUNT_MAX : int'(t);
        endfunction

        function void clear_flags();
            fl_online = 1'b0;
            fl_chip = 1'b0;
            fl_short = 1'b0;
        endfunction

        function void advance(pdas_pkg::item_t it);
            ev_alarm = pdas_pkg::ALARM_NONE;
            ev_screen = pdas_pkg::SCREEN_NONE;
            ev_stop = 1'b0;
            if (!it.plugged)
            begin
                insert_count = 0;
                delay_count = 0;
                if (stage == ST_ONLINE || stage == ST_DEB_OUT || stage == ST_FAIL)
                begin
                    if (stage != ST_DEB_OUT)
                    begin
                        remove_count = 0;
                        stage = ST_DEB_OUT;
                    end
                    if (remove_count < limit(regs.remove_debounce_ticks))
                    begin
                        remove_count++;
                        return;
                    end
                    remove_count = 0;
                    stage = ST_IDLE;
                    clear_flags();
                    model = '0;
                    ev_screen = pdas_pkg::SCREEN_OFFLINE;
                    if (it.motor_running)
                    begin
                        ev_alarm = pdas_pkg::ALARM_RUN_UNPLUG;
                        ev_stop = 1'b1;
                    end
                    return;
                end
                // early stages drop straight back to idle
                remove_count = 0;
                stage = ST_IDLE;
                clear_flags();
                return;
            end
            if (stage == ST_IDLE)
            begin
                insert_count = 0;
                remove_count = 0;
                delay_count = 0;
                stage = ST_DEB_IN;
            end
            if (stage == ST_DEB_IN)
            begin
                if (insert_count < limit(regs.insert_debounce_ticks))
                begin
                    insert_count++;
                    return;
                end
                insert_count = 0;
                delay_count = 0;
                stage = ST_WAIT;
                fl_short = 1'b1;
                return;
            end
            if (stage == ST_WAIT)
            begin
                if (delay_count < limit(regs.verify_delay_ticks))
                begin
                    delay_count++;
                    return;
                end
                delay_count = 0;
                stage = ST_VERIFY;
            end
            if (stage == ST_VERIFY)
            begin
                if (!it.verify_ok)
                begin
                    ev_alarm = pdas_pkg::ALARM_VERIFY_FAIL;
                    stage = ST_FAIL;
                    return;
                end
                stage = ST_INFO;
            end
            if (stage == ST_INFO)
            begin
                if (!it.info_read_ok || it.id_major != regs.expected_major_id ||
                    it.id_minor == 8'd0 || it.id_minor > regs.known_type_count)
                begin
                    ev_alarm = pdas_pkg::ALARM_INFO_FAIL;
                    stage = ST_FAIL;
                    return;
                end
                model = it.id_minor;
                fl_online = 1'b1;
                fl_chip = 1'b1;
                fl_short = 1'b1;
                ev_screen = pdas_pkg::SCREEN_ONLINE;
                stage = ST_ONLINE;
            end
        endfunction

        function void note_item(pdas_pkg::item_t it);
            pdas_pkg::result_t r;
            advance(it);
            r.stage = stage;
            r.online = fl_online;
            r.chip_recognized = fl_chip;
            r.short_recognized = fl_short;
            r.model_index = model;
            r.alarm_code = ev_alarm;
            r.motor_stop = ev_stop;
            r.screen_event = ev_screen;
            due_status.push_back(r);
        endfunction

        function void check_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(pdas_pkg::result_t got);
            pdas_pkg::result_t want;
            if (due_status.size() == 0)
            begin
                errors++;
                $display("%0t: result %h with nothing expected, expected none, actual %h",
                         $time, got, got);
                return;
            end
            want = due_status.pop_front();
            check_field("stage", 8'(want.stage), 8'(got.stage));
            check_field("online", 8'(want.online), 8'(got.online));
            check_field("chip_recognized", 8'(want.chip_recognized),
                        8'(got.chip_recognized));
            check_field("short_recognized", 8'(want.short_recognized),
                        8'(got.short_recognized));
            check_field("model_index", want.model_index, got.model_index);
            check_field("alarm_code", 8'(want.alarm_code), 8'(got.alarm_code));
            check_field("motor_stop", 8'(want.motor_stop), 8'(got.motor_stop));
            check_field("screen_event", 8'(want.screen_event), 8'(got.screen_event));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_stall;
    pdas_pkg::item_t item = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    pdas_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    int send_idle = 37;
    int recv_stall = 68;
    status_scoreboard sb;

    plug_detect_auth_sequencer #(.COUNTER_WIDTH(COUNTER_WIDTH)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            sb.check_result(result);
        end
        result_stall <= ($urandom_range(99) < recv_stall);
    end

    task automatic send_item(pdas_pkg::item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        sb.note_item(it);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // unknown index goes last so an aliased decode would show up
    task automatic configure(pdas_pkg::cfg_t c);
        for (int i = pdas_pkg::REG_INSERT_DEBOUNCE; i <= pdas_pkg::REG_KNOWN_TYPES; i++)
        begin
            write_reg(INDEX_W'(i), c[(pdas_pkg::REG_KNOWN_TYPES - i) * 8 +: 8]);
        end
        write_reg(INDEX_W'($urandom_range((1 << INDEX_W) - 1,
                                          pdas_pkg::REG_KNOWN_TYPES + 1)),
                  8'($urandom_range(255)));
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        while (sb.due_status.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic pdas_pkg::item_t tick_item(logic p, logic v, logic inf, logic [7:0] maj,
                                                  logic [7:0] minor_id, logic motor);
        return pdas_pkg::item_t'{p, v, inf, maj, minor_id, motor};
    endfunction

    function automatic pdas_pkg::item_t pick_item(logic plugged);
        pdas_pkg::item_t it;
        int roll;
        logic [7:0] known;
        known = sb.regs.known_type_count;
        it.plugged = plugged;
        it.verify_ok = ($urandom_range(99) < 85);
        it.info_read_ok = ($urandom_range(99) < 85);
        it.id_major = ($urandom_range(99) < 80) ? sb.regs.expected_major_id
                                                : 8'($urandom_range(255));
        roll = $urandom_range(9);
        if (roll == 0)
            it.id_minor = 8'd0;
        else if (roll == 1)
            it.id_minor = 8'(known + 1);
        else if (roll == 2 || known == 8'd0)
            it.id_minor = 8'($urandom_range(255));
        else
            it.id_minor = 8'($urandom_range(known, 1));
        it.motor_running = 1'($urandom_range(1));
        return it;
    endfunction

    // insert runs mostly long enough to reach verification, removal runs mostly to offline
    task automatic run_traffic(int n);
        int sent;
        int len;
        int ins_full;
        int rem_full;
        sent = 0;
        while (sent < n)
        begin
            ins_full = sb.regs.insert_debounce_ticks + sb.regs.verify_delay_ticks + 2;
            rem_full = sb.regs.remove_debounce_ticks + 1;
            len = ($urandom_range(9) < 2) ? $urandom_range(ins_full, 1)
                                          : ins_full + $urandom_range(12);
            if (len > n - sent)
                len = n - sent;
            repeat (len)
            begin
                send_item(pick_item(1'b1));
                sent++;
            end
            len = ($urandom_range(9) < 2) ? $urandom_range(rem_full, 1)
                                          : rem_full + $urandom_range(4);
            if (len > n - sent)
                len = n - sent;
            repeat (len)
            begin
                send_item(pick_item(1'b0));
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: insert debounce then silent drop from wait
        repeat (6) send_item(tick_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        settle();
        configure(pdas_pkg::cfg_t'{8'd0, 8'd1, 8'd0, pdas_pkg::RST_EXPECTED_MAJOR,
                                   pdas_pkg::RST_KNOWN_TYPES});

        // verify failure, reinsertion during removal, running unplug
        send_item(tick_item(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b1));
        send_item(tick_item(1'b1, 1'b0, 1'b1, 8'hFF, 8'h01, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b1, pdas_pkg::RST_EXPECTED_MAJOR, 8'h05, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
        send_item(tick_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
        send_item(tick_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b1));
        // info read failure
        send_item(tick_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b0, pdas_pkg::RST_EXPECTED_MAJOR, 8'h01, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 1'b0));
        // minor id just above the known range
        send_item(tick_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b1, pdas_pkg::RST_EXPECTED_MAJOR, 8'd13, 1'b1));
        send_item(tick_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        send_item(tick_item(1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        // online at the top of the known range, then removal with motor running
        send_item(tick_item(1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0));
        send_item(tick_item(1'b1, 1'b1, 1'b1, pdas_pkg::RST_EXPECTED_MAJOR,
                            pdas_pkg::RST_KNOWN_TYPES, 1'b1));
        send_item(tick_item(1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 1'b1));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 8'h00, 8'hFF, 1'b1));
        send_item(tick_item(1'b0, 1'b1, 1'b1, 8'h00, 8'hFF, 1'b1));
        settle();

        configure(pdas_pkg::cfg_t'{8'd2, 8'd3, 8'd4, pdas_pkg::RST_EXPECTED_MAJOR,
                                   pdas_pkg::RST_KNOWN_TYPES});
        run_traffic(500);
        settle();

        send_idle = 68;
        recv_stall = 37;
        configure(pdas_pkg::cfg_t'{8'd0, 8'd0, 8'd0, 8'h00, 8'hFF});
        run_traffic(300);
        settle();

        send_idle = 0;
        recv_stall = 0;
        configure(pdas_pkg::cfg_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
        run_traffic(700);
        settle();

        configure(pdas_pkg::cfg_t'{8'($urandom_range(6)), 8'($urandom_range(6)),
                                   8'($urandom_range(6)), 8'($urandom_range(255)),
                                   8'($urandom_range(40, 1))});
        run_traffic(450);
        settle();

        if (sb.errors == 0)
            $display("plug_detect_auth_sequencer_tb passed");
        else
            $display("plug_detect_auth_sequencer_tb failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("plug_detect_auth_sequencer_tb failed");
        $finish;
    end

endmodule
